[rtl/core/ukst_pkg.sv]
// Shared types, constants and lookup tables for the ultrasonic slope tracker.
`timescale 1ns / 1ps
package ukst_pkg;

   localparam int MAX_WINDOW   = 16;
   localparam int ECHO_W       = 16;
   localparam int DIST_W       = 19;
   localparam int EST_W        = 20;
   localparam int VAR_W        = 24;
   localparam int GAIN_W       = 17;
   localparam int SLOPE_W      = 21;
   localparam int SS_W         = 24;
   localparam int SIW_W        = 28;
   localparam int CNT_W        = 5;
   localparam int DIV_W        = 41;
   localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 104;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [DIST_W-1:0]  DIST_MAX  = 19'd524287;
   localparam logic [VAR_W-1:0]   VAR_MAX   = 24'hFFFFFF;
   localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'h10000;

   // Register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MEASUREMENT_NOISE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_LEN        = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CM_PER_US_SCALE   = 2'd3;

   typedef struct packed {
      logic [9:0]  process_noise;
      logic [9:0]  measurement_noise;
      logic [4:0]  window_len;
      logic [15:0] cm_per_us_scale;
   } ukst_cfg_type;

   typedef struct packed {
      logic [ECHO_W-1:0] front_echo_us;
      logic [ECHO_W-1:0] right_echo_us;
      logic [ECHO_W-1:0] left_echo_us;
   } ukst_item_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } ukst_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
   } ukst_div_rsp_type;

   // Sum of indices 0..m-1
   function automatic logic [6:0] slope_sx(input logic [CNT_W-1:0] m);
      logic [9:0] prod;
      prod = 10'({5'd0, m} * ({5'd0, m} - 10'd1));
      return prod[7:1];
   endfunction

   // m * sum(i^2) - (sum i)^2 over indices 0..m-1
   function automatic logic [12:0] slope_den(input logic [CNT_W-1:0] m);
      logic [12:0] d;
      unique case (m)
         5'd2:    d = 13'd1;
         5'd3:    d = 13'd6;
         5'd4:    d = 13'd20;
         5'd5:    d = 13'd50;
         5'd6:    d = 13'd105;
         5'd7:    d = 13'd196;
         5'd8:    d = 13'd336;
         5'd9:    d = 13'd540;
         5'd10:   d = 13'd825;
         5'd11:   d = 13'd1210;
         5'd12:   d = 13'd1716;
         5'd13:   d = 13'd2366;
         5'd14:   d = 13'd3185;
         5'd15:   d = 13'd4200;
         5'd16:   d = 13'd5440;
         default: d = 13'd0;
      endcase
      return d;
   endfunction

endpackage

[rtl/core/ultrasonic_kalman_slope_tracker.sv]
// Top level: configuration registers, input queue, datapath and divider.
//
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/req_tready  tdata: left, right, front echo (us)
//  rsp_     out  rsp_tvalid/rsp_tready  tdata: 4 filtered values, slope; tuser
//  csr_     in   csr_we                 csr_addr index, csr_wdata value
//
// Each item uses the shared 41-step divider for the gain, then, when it closes
// a regression window, again for the slope.
// With a zero gain denominator the gain division is skipped.
// Reset is synchronous: estimates, variance, window sums and slope clear.
// The two-entry input queue keeps taking beats while it has room and the
// datapath works; a finished result waits in the output register until rsp_tready.
`timescale 1ns / 1ps
module ultrasonic_kalman_slope_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] left_echo_us, [31:16] right_echo_us, [47:32] front_echo_us
   input  logic [ukst_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [18:0] left_filtered, [37:19] right_filtered, [56:38] front_filtered,
   // [75:57] midline_filtered, [96:76] deviation_slope, rest zero
   output logic [ukst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] slope_new
   output logic                            rsp_tuser,
   input  logic                            csr_we,
   input  logic [ukst_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ukst_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ukst_pkg::*;

   ukst_cfg_type     cfg_ff;
   logic             item_valid;
   ukst_item_type    item;
   logic             item_pop;
   ukst_div_req_type div_req;
   ukst_div_rsp_type div_rsp;

   // Configuration registers; each write keeps only the register's width
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.process_noise     <= 10'd10;
         cfg_ff.measurement_noise <= 10'd40;
         cfg_ff.window_len        <= 5'd10;
         cfg_ff.cm_per_us_scale   <= 16'd2252;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_PROCESS_NOISE:     cfg_ff.process_noise     <= csr_wdata[9:0];
            CSR_MEASUREMENT_NOISE: cfg_ff.measurement_noise <= csr_wdata[9:0];
            CSR_WINDOW_LEN:        cfg_ff.window_len        <= csr_wdata[4:0];
            CSR_CM_PER_US_SCALE:   cfg_ff.cm_per_us_scale   <= csr_wdata;
            default:               cfg_ff                   <= cfg_ff;
         endcase
      end
   end

   // Front: hold incoming beats until the datapath is free
   ukst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   // Back: one item at a time through distance, filter, variance and window steps
   ukst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Shared divider for the Kalman gain and the regression slope
   ukst_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

[rtl/core/ukst_front.sv]
// Input side: two-entry queue that takes request beats ahead of the datapath.
`timescale 1ns / 1ps
module ukst_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ukst_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                          item_valid,
   output ukst_pkg::ukst_item_type       item,
   input  logic                          item_pop
);
   import ukst_pkg::*;

   ukst_item_type item_ff [2];
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;
   logic [1:0]    count_ff;
   logic          push;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = item_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= ukst_item_type'(req_tdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (item_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(item_pop);
      end
   end

endmodule

[rtl/core/ukst_div.sv]
// Restoring divider, one quotient bit per cycle, shared by gain and slope.
`timescale 1ns / 1ps
module ukst_div (
   input  logic                       clock,
   input  logic                       reset,
   input  ukst_pkg::ukst_div_req_type div_req,
   output ukst_pkg::ukst_div_rsp_type div_rsp
);
   import ukst_pkg::*;

   logic [DIV_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     quot_ff;
   logic [DIV_W-1:0]     den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_W:0]       rem_sh;
   logic                 bit_in;
   logic [DIV_W-1:0]     rem_in;

   always_comb begin
      rem_sh = {rem_ff, quot_ff[DIV_W-1]};
      bit_in = (rem_sh >= {1'b0, den_ff});
      rem_in = bit_in ? DIV_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            rem_ff  <= '0;
            quot_ff <= div_req.num;
            den_ff  <= div_req.den;
            cnt_ff  <= DIV_CNT_W'(DIV_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quot_ff <= {quot_ff[DIV_W-2:0], bit_in};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

[rtl/core/ukst_back.sv]
// Datapath sequencer: distances, Kalman updates, variance, window regression.
`timescale 1ns / 1ps
module ukst_back (
   input  logic                            clock,
   input  logic                            reset,
   input  ukst_pkg::ukst_cfg_type          cfg,
   input  logic                            item_valid,
   input  ukst_pkg::ukst_item_type         item,
   output logic                            item_pop,
   output ukst_pkg::ukst_div_req_type      div_req,
   input  ukst_pkg::ukst_div_rsp_type      div_rsp,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ukst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser
);
   import ukst_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MEAS, S_GDIV, S_GWAIT, S_KMUL, S_KADD, S_VMUL, S_VADD,
      S_WIN, S_NMUL, S_NSUB, S_SWAIT, S_OUT
   } state_type;

   localparam logic signed [23:0] DIST_LO = 24'sd0;
   localparam logic signed [23:0] DIST_HI = 24'sd524287;
   localparam logic signed [23:0] MID_LO  = -24'sd262144;
   localparam logic signed [23:0] MID_HI  = 24'sd262143;
   localparam logic signed [SLOPE_W-1:0] SLOPE_LO = {1'b1, {(SLOPE_W-1){1'b0}}};
   localparam logic signed [SLOPE_W-1:0] SLOPE_HI = {1'b0, {(SLOPE_W-1){1'b1}}};

   state_type                 state_ff;
   ukst_item_type             item_ff;
   logic [1:0]                ch_ff;
   logic [DIST_W-1:0]         meas_ff [3];
   logic signed [EST_W-1:0]   est_ff [4];
   logic [VAR_W-1:0]          p_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic signed [38:0]        kprod_ff;
   logic [40:0]               vprod_ff;
   logic [CNT_W-1:0]          wcnt_ff;
   logic [CNT_W-1:0]          m_ff;
   logic signed [SS_W-1:0]    ss_ff;
   logic signed [SIW_W-1:0]   siw_ff;
   logic signed [34:0]        t1_ff;
   logic signed [31:0]        t2_ff;
   logic                      neg_ff;
   logic signed [SLOPE_W-1:0] slope_ff;
   logic                      fresh_ff;
   ukst_div_req_type          div_req_ff;
   logic                      rsp_valid_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic                      rsp_user_ff;

   logic [ECHO_W-1:0]         echo;
   logic [30:0]               dprod;
   logic [DIST_W-1:0]         dist_in;
   logic [24:0]               gden;
   logic signed [20:0]        mid_diff;
   logic signed [20:0]        mid_half;
   logic signed [EST_W-1:0]   k_meas;
   logic signed [20:0]        k_diff;
   logic signed [38:0]        kprod_in;
   logic signed [23:0]        k_sum;
   logic signed [EST_W-1:0]   est_in;
   logic [25:0]               vsum;
   logic [VAR_W-1:0]          p_in;
   logic [CNT_W-1:0]          n_eff;
   logic [CNT_W-1:0]          c_next;
   logic signed [25:0]        cy;
   logic signed [SS_W-1:0]    ss_in;
   logic signed [SIW_W-1:0]   siw_in;
   logic signed [34:0]        num;
   logic [34:0]               num_mag;
   logic [12:0]               dn;
   logic signed [SLOPE_W-1:0] slope_in;
   logic                      rsp_load;
   logic                      div_start;

   always_comb begin
      unique case (ch_ff)
         2'd0:    echo = item_ff.left_echo_us;
         2'd1:    echo = item_ff.right_echo_us;
         default: echo = item_ff.front_echo_us;
      endcase
      dprod   = 31'(echo[ECHO_W-1:1] * cfg.cm_per_us_scale);
      dist_in = (dprod[30:8] > 23'(DIST_MAX)) ? DIST_MAX : dprod[26:8];
      gden    = 25'(p_ff) + {7'd0, cfg.measurement_noise, 8'd0};

      // Midline measurement: floor of half the filtered left-right difference
      mid_diff = 21'(est_ff[0]) - 21'(est_ff[1]);
      mid_half = mid_diff >>> 1;
      k_meas   = (ch_ff == 2'd3) ? mid_half[EST_W-1:0] : $signed({1'b0, meas_ff[ch_ff]});
      k_diff   = 21'(k_meas) - 21'(est_ff[ch_ff]);
      kprod_in = $signed({1'b0, gain_ff}) * k_diff;
      k_sum    = 24'(est_ff[ch_ff]) + 24'($signed(kprod_ff[38:16]));
      if (ch_ff == 2'd3) begin
         est_in = (k_sum < MID_LO) ? EST_W'(MID_LO) :
                  (k_sum > MID_HI) ? EST_W'(MID_HI) : k_sum[EST_W-1:0];
      end else begin
         est_in = (k_sum < DIST_LO) ? EST_W'(DIST_LO) :
                  (k_sum > DIST_HI) ? EST_W'(DIST_HI) : k_sum[EST_W-1:0];
      end

      vsum = {1'b0, vprod_ff[40:16]} + {8'd0, cfg.process_noise, 8'd0};
      p_in = (vsum > 26'(VAR_MAX)) ? VAR_MAX : vsum[VAR_W-1:0];

      priority if (cfg.window_len < 5'd2) begin
         n_eff = 5'd2;
      end else if (cfg.window_len > CNT_W'(MAX_WINDOW)) begin
         n_eff = CNT_W'(MAX_WINDOW);
      end else begin
         n_eff = cfg.window_len;
      end
      c_next = wcnt_ff + 1'b1;
      cy     = $signed({1'b0, wcnt_ff}) * est_ff[3];
      ss_in  = ss_ff + SS_W'(est_ff[3]);
      siw_in = siw_ff + SIW_W'(cy);

      num     = t1_ff - 35'(t2_ff);
      num_mag = num[34] ? 35'(-num) : 35'(num);
      dn      = slope_den(m_ff);
      if (neg_ff) begin
         slope_in = (div_rsp.quot > DIV_W'(1048576)) ? SLOPE_LO :
                    SLOPE_W'(-$signed({1'b0, div_rsp.quot[SLOPE_W-1:0]}));
      end else begin
         slope_in = (div_rsp.quot > DIV_W'(1048575)) ? SLOPE_HI :
                    $signed(div_rsp.quot[SLOPE_W-1:0]);
      end
   end

   assign item_pop  = (state_ff == S_IDLE) && item_valid;
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign div_start = ((state_ff == S_GDIV) && (gden != '0)) ||
                      ((state_ff == S_NSUB) && (dn != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= 2'd0;
         est_ff       <= '{default: '0};
         p_ff         <= '0;
         gain_ff      <= '0;
         wcnt_ff      <= '0;
         ss_ff        <= '0;
         siw_ff       <= '0;
         slope_ff     <= '0;
         fresh_ff     <= 1'b0;
         div_req_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_req_ff.start <= div_start;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  item_ff  <= item;
                  ch_ff    <= 2'd0;
                  fresh_ff <= 1'b0;
                  state_ff <= S_MEAS;
               end
            end
            S_MEAS: begin
               meas_ff[ch_ff] <= dist_in;
               if (ch_ff == 2'd2) begin
                  state_ff <= S_GDIV;
               end else begin
                  ch_ff <= ch_ff + 2'd1;
               end
            end
            S_GDIV: begin
               ch_ff <= 2'd0;
               if (gden == '0) begin
                  gain_ff  <= '0;
                  state_ff <= S_KMUL;
               end else begin
                  div_req_ff.num   <= {1'b0, p_ff, 16'd0};
                  div_req_ff.den   <= DIV_W'(gden);
                  state_ff         <= S_GWAIT;
               end
            end
            S_GWAIT: begin
               if (div_rsp.done) begin
                  gain_ff  <= div_rsp.quot[GAIN_W-1:0];
                  state_ff <= S_KMUL;
               end
            end
            S_KMUL: begin
               kprod_ff <= kprod_in;
               state_ff <= S_KADD;
            end
            S_KADD: begin
               est_ff[ch_ff] <= est_in;
               if (ch_ff == 2'd3) begin
                  state_ff <= S_VMUL;
               end else begin
                  ch_ff    <= ch_ff + 2'd1;
                  state_ff <= S_KMUL;
               end
            end
            S_VMUL: begin
               vprod_ff <= 41'((GAIN_ONE - gain_ff) * p_ff);
               state_ff <= S_VADD;
            end
            S_VADD: begin
               p_ff     <= p_in;
               state_ff <= S_WIN;
            end
            S_WIN: begin
               ss_ff   <= ss_in;
               siw_ff  <= siw_in;
               wcnt_ff <= c_next;
               m_ff    <= c_next;
               if (c_next >= n_eff) begin
                  state_ff <= S_NMUL;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_NMUL: begin
               t1_ff    <= $signed({1'b0, m_ff}) * siw_ff;
               t2_ff    <= $signed({1'b0, slope_sx(m_ff)}) * ss_ff;
               state_ff <= S_NSUB;
            end
            S_NSUB: begin
               neg_ff <= num[34];
               if (dn == '0) begin
                  slope_ff <= '0;
                  fresh_ff <= 1'b1;
                  wcnt_ff  <= '0;
                  ss_ff    <= '0;
                  siw_ff   <= '0;
                  state_ff <= S_OUT;
               end else begin
                  div_req_ff.num   <= DIV_W'(num_mag);
                  div_req_ff.den   <= DIV_W'(dn);
                  state_ff         <= S_SWAIT;
               end
            end
            S_SWAIT: begin
               if (div_rsp.done) begin
                  slope_ff <= slope_in;
                  fresh_ff <= 1'b1;
                  wcnt_ff  <= '0;
                  ss_ff    <= '0;
                  siw_ff   <= '0;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_data_ff  <= {7'd0, slope_ff, est_ff[3][DIST_W-1:0],
                                   est_ff[2][DIST_W-1:0], est_ff[1][DIST_W-1:0],
                                   est_ff[0][DIST_W-1:0]};
                  rsp_user_ff  <= fresh_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign div_req    = div_req_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= GAIN_ONE) else $error("gain above unity");

   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      wcnt_ff <= CNT_W'(MAX_WINDOW)) else $error("window count out of range");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_GWAIT || state_ff == S_SWAIT))
      else $error("divider result with no waiting step");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      item_pop |=> (state_ff == S_MEAS && ch_ff == 2'd0))
      else $error("item taken without starting distance step");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the ultrasonic Kalman slope tracker.
`timescale 1ns / 1ps
module testbench;
   import ukst_pkg::*;

   localparam int IDLE_WAIT   = 30;     // cycles to let the datapath settle after last beat
   localparam int STALL_LIMIT = 20000;  // cycles with no beat before the run is abandoned
   localparam int HOLD_AT     = 150;    // result beat after which the receiver holds off
   localparam int HOLD_LEN    = 400;

   typedef struct {
      logic [18:0] left_cm;
      logic [18:0] right_cm;
      logic [18:0] front_cm;
      logic [18:0] mid_cm;
      logic [20:0] slope;
      logic        slope_new;
   } track_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ultrasonic_kalman_slope_tracker i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the registers
   logic [9:0]  sh_q;
   logic [9:0]  sh_r;
   logic [4:0]  sh_win;
   logic [15:0] sh_scale;

   // Shadow copy of the filter and window state
   int      est_left, est_right, est_front, est_mid;
   longint  err_var;
   int      win_count;
   longint  sum_y, sum_cy;
   int      slope_held;

   ukst_item_type echo_q[$];         // items waiting for the driver
   track_result_type track_q[$];     // results expected from the block
   int err_count;
   bit burst_mode;                   // no idling on either side while set

   function automatic int echo_to_cm(logic [15:0] echo);
      longint d;
      d = (longint'(echo >> 1) * longint'(sh_scale)) >>> 8;
      if (d > 524287) d = 524287;
      return int'(d);
   endfunction

   function automatic int filter_step(int est, int meas, longint gain, longint lo, longint hi);
      longint nx;
      nx = longint'(est) + ((gain * (longint'(meas) - longint'(est))) >>> 16);
      if (nx < lo) nx = lo;
      if (nx > hi) nx = hi;
      return int'(nx);
   endfunction

   // Advance the shadow tracker by one ping and queue the result it must produce
   task automatic track_ping(ukst_item_type it);
      longint p, den, gain, np, m, sx, sxx, num, dn, b;
      int mid_meas, n;
      track_result_type r;
      p = err_var;
      den = p + (longint'(sh_r) << 8);
      gain = (den == 0) ? 0 : (p << 16) / den;
      est_left  = filter_step(est_left,  echo_to_cm(it.left_echo_us),  gain, 0, 524287);
      est_right = filter_step(est_right, echo_to_cm(it.right_echo_us), gain, 0, 524287);
      est_front = filter_step(est_front, echo_to_cm(it.front_echo_us), gain, 0, 524287);
      mid_meas = (est_left - est_right) >>> 1;
      est_mid = filter_step(est_mid, mid_meas, gain, -262144, 262143);
      np = (((65536 - gain) * p) >>> 16) + (longint'(sh_q) << 8);
      if (np > 16777215) np = 16777215;
      err_var = np;
      n = sh_win;
      if (n < 2) n = 2;
      if (n > MAX_WINDOW) n = MAX_WINDOW;
      sum_y  += est_mid;
      sum_cy += longint'(win_count) * est_mid;
      win_count++;
      r.slope_new = 1'b0;
      if (win_count >= n) begin
         m = win_count;
         sx = m * (m - 1) / 2;
         sxx = (m - 1) * m * (2 * m - 1) / 6;
         num = m * sum_cy - sx * sum_y;
         dn = m * sxx - sx * sx;
         b = (dn != 0) ? num / dn : 0;
         if (b < -1048576) b = -1048576;
         if (b > 1048575) b = 1048575;
         slope_held = int'(b);
         r.slope_new = 1'b1;
         win_count = 0;
         sum_y = 0;
         sum_cy = 0;
      end
      r.left_cm  = est_left[18:0];
      r.right_cm = est_right[18:0];
      r.front_cm = est_front[18:0];
      r.mid_cm   = est_mid[18:0];
      r.slope    = slope_held[20:0];
      track_q.push_back(r);
   endtask

   // ---------------- driver: feed pings from echo_q ----------------
   ukst_item_type cur_item;
   int req_gap;

   always @(posedge clock) begin
      bit fire;
      bit nv;
      fire = req_tvalid && req_tready;
      nv = req_tvalid;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (fire) track_ping(cur_item);
         if (!req_tvalid || fire) begin
            nv = 1'b0;
            if (req_gap > 0) begin
               // hold the bus idle for the drawn gap
               req_gap <= req_gap - 1;
            end else if (echo_q.size() > 0) begin
               cur_item = echo_q.pop_front();
               req_tdata <= cur_item;
               nv = 1'b1;
               req_gap <= burst_mode ? 0 : int'($urandom_range(0, 9));
            end
         end
         req_tvalid <= nv;
      end
   end

   // ---------------- monitor: check each result beat ----------------
   int rsp_stall;
   int rsp_hold;
   int rsp_beats;

   always @(posedge clock) begin
      track_result_type e;
      bit fire;
      fire = rsp_tvalid && rsp_tready;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
         rsp_hold <= 0;
         rsp_beats <= 0;
      end else begin
         if (fire) begin
            if (track_q.size() == 0) begin
               $error("result beat with nothing expected");
               err_count++;
            end else begin
               e = track_q.pop_front();
               if (rsp_tdata[18:0] !== e.left_cm) begin
                  $error("left_filtered exp %0d got %0d", e.left_cm, rsp_tdata[18:0]);
                  err_count++;
               end
               if (rsp_tdata[37:19] !== e.right_cm) begin
                  $error("right_filtered exp %0d got %0d", e.right_cm, rsp_tdata[37:19]);
                  err_count++;
               end
               if (rsp_tdata[56:38] !== e.front_cm) begin
                  $error("front_filtered exp %0d got %0d", e.front_cm, rsp_tdata[56:38]);
                  err_count++;
               end
               if (rsp_tdata[75:57] !== e.mid_cm) begin
                  $error("midline_filtered exp %0d got %0d",
                         $signed(e.mid_cm), $signed(rsp_tdata[75:57]));
                  err_count++;
               end
               if (rsp_tdata[96:76] !== e.slope) begin
                  $error("deviation_slope exp %0d got %0d",
                         $signed(e.slope), $signed(rsp_tdata[96:76]));
                  err_count++;
               end
               if (rsp_tuser !== e.slope_new) begin
                  $error("slope_new exp %0d got %0d", e.slope_new, rsp_tuser);
                  err_count++;
               end
            end
            rsp_beats <= rsp_beats + 1;
            // long hold-off once, so the input queue fills and backs up
            if (rsp_beats + 1 == HOLD_AT) rsp_hold <= HOLD_LEN;
            rsp_stall <= burst_mode ? 0 : int'($urandom_range(0, 9));
            rsp_tready <= 1'b0;
         end else if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------- watchdog ----------------
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic csr_write(logic [CSR_ADDR_W-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_PROCESS_NOISE:     sh_q = val[9:0];
         CSR_MEASUREMENT_NOISE: sh_r = val[9:0];
         CSR_WINDOW_LEN:        sh_win = val[4:0];
         CSR_CM_PER_US_SCALE:   sh_scale = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_all(logic [9:0] q, logic [9:0] r, logic [4:0] w, logic [15:0] s);
      csr_write(CSR_PROCESS_NOISE, 16'(q));
      csr_write(CSR_MEASUREMENT_NOISE, 16'(r));
      csr_write(CSR_WINDOW_LEN, 16'(w));
      csr_write(CSR_CM_PER_US_SCALE, s);
   endtask

   task automatic push_ping(logic [15:0] l, logic [15:0] r, logic [15:0] f);
      ukst_item_type it;
      it.left_echo_us = l;
      it.right_echo_us = r;
      it.front_echo_us = f;
      echo_q.push_back(it);
   endtask

   // Drain everything in flight before touching the registers; check again after
   // the settle time in case a beat was just being handed to the bus
   task automatic wait_idle();
      do begin
         while (echo_q.size() != 0 || req_tvalid || track_q.size() != 0) @(posedge clock);
         repeat (IDLE_WAIT) @(posedge clock);
      end while (echo_q.size() != 0 || req_tvalid || track_q.size() != 0);
   endtask

   // Mostly a plausible drifting target, with a share of full-range noise
   task automatic random_pings(int count);
      logic [15:0] base_l, base_r;
      base_l = 16'($urandom_range(200, 20000));
      base_r = 16'($urandom_range(200, 20000));
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 2) begin
            push_ping(16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            base_l = 16'(base_l + $urandom_range(0, 400) - 200);
            base_r = 16'(base_r + $urandom_range(0, 400) - 200);
            push_ping(base_l, base_r, 16'($urandom_range(0, 40000)));
         end
         if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      err_count = 0;
      burst_mode = 1'b0;
      sh_q = 10'd10;
      sh_r = 10'd40;
      sh_win = 5'd10;
      sh_scale = 16'd2252;
      est_left = 0; est_right = 0; est_front = 0; est_mid = 0;
      err_var = 0; win_count = 0; sum_y = 0; sum_cy = 0; slope_held = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero noise on both sides: variance stays zero, denominator is zero
      set_all(10'd0, 10'd0, 5'd0, 16'd2252);
      push_ping(16'd0, 16'd0, 16'd0);
      push_ping(16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_ping(16'd1000, 16'd2000, 16'd3000);
      wait_idle();

      // full-scale factor drives distances into saturation
      set_all(10'd1023, 10'd1, 5'd2, 16'hFFFF);
      push_ping(16'hFFFF, 16'd0, 16'hFFFF);
      push_ping(16'hFFFF, 16'd0, 16'h8000);
      push_ping(16'd0, 16'hFFFF, 16'd1);
      push_ping(16'd0, 16'hFFFF, 16'd0);
      push_ping(16'h5555, 16'hAAAA, 16'h00FF);
      wait_idle();

      // long window, then shorten it mid-window so the next sample closes it
      set_all(10'd10, 10'd40, 5'd31, 16'd2252);
      for (int i = 0; i < 7; i++) push_ping(16'(i * 900), 16'(8000 - i * 700), 16'd5000);
      wait_idle();
      csr_write(CSR_WINDOW_LEN, 16'd3);
      push_ping(16'd7000, 16'd100, 16'd5000);
      push_ping(16'd100, 16'd7000, 16'd5000);
      wait_idle();

      // window length of one acts as two
      csr_write(CSR_WINDOW_LEN, 16'd1);
      push_ping(16'd400, 16'd300, 16'd200);
      push_ping(16'd9000, 16'd300, 16'd200);
      wait_idle();

      // random phases, extremes among the settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_all(10'd10, 10'd40, 5'd10, 16'd2252);
            1: set_all(10'd0, 10'd1023, 5'd16, 16'd1);
            2: set_all(10'd1023, 10'd1, 5'd2, 16'hFFFF);
            default: set_all(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                             5'($urandom_range(0, 31)), 16'($urandom_range(1, 65535)));
         endcase
         random_pings(80);
         wait_idle();
      end

      wait_idle();
      if (err_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
